// ----- sv/pqu_pkg.sv -----
// Package for the plane query unit: request and result structs, command codes,
// side codes and register indexes. No dependencies.
package pqu_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegNormalX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNormalY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNormalZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffset = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd4;

  localparam logic [2:0] CmdPoint = 3'd0;
  localparam logic [2:0] CmdBox = 3'd1;
  localparam logic [2:0] CmdSphere = 3'd2;
  localparam logic [2:0] CmdRay = 3'd3;
  localparam logic [2:0] CmdProject = 3'd4;

  localparam logic [1:0] SideNeg = 2'd0;
  localparam logic [1:0] SidePos = 2'd1;
  localparam logic [1:0] SideOn = 2'd2;
  localparam logic [1:0] SideBoth = 2'd3;

  // Quotient bits: 16 integer bits plus one overflow bit, then 16 fraction bits.
  localparam int unsigned QuotW = 33;
  localparam int unsigned NumW = 63;
  localparam int unsigned DenW = 48;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] extent_x;
    logic signed [31:0] extent_y;
    logic signed [31:0] extent_z;
    logic [30:0]        radius;
  } req_t;

  typedef struct packed {
    logic [1:0]         side;
    logic signed [31:0] distance;
    logic               hit;
    logic signed [31:0] ray_t;
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
  } res_t;

  function automatic logic signed [31:0] sat_shift(input logic signed [79:0] v,
                                                   input int unsigned k);
    logic signed [79:0] r;
    r = (v + (80'sd1 <<< (k - 1))) >>> k;
    if (r > 80'sd2147483647) return 32'sh7fffffff;
    if (r < -80'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

endpackage

// ----- sv/pqu_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, one request per cycle
// when en_i is high. Depends on pqu_pkg. Each division carries a side-data tag.
module pqu_divider import pqu_pkg::*; #(
  parameter int unsigned TagW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [TagW-1:0]  tag_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_o,
  output logic [TagW-1:0]  tag_o
);

  localparam int unsigned RemW = DenW + 1;
  // Numerator is scaled by 2^16; stage s tests bit (QuotW-1-s) of the quotient.
  localparam int unsigned ExtW = NumW + 16;

  logic [QuotW-1:0]           vld_q;
  logic [ExtW-1:0]            num_q [QuotW];
  logic [RemW-1:0]            rem_q [QuotW];
  logic [DenW-1:0]            den_q [QuotW];
  logic [QuotW-1:0]           quo_q [QuotW];
  logic [TagW-1:0]            tag_q [QuotW];

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    logic             vld_in;
    logic [ExtW-1:0]  num_in;
    logic [DenW-1:0]  den_in;
    logic [QuotW-1:0] quo_in;
    logic [TagW-1:0]  tag_in;
    logic [RemW:0]    trial;
    logic [RemW-1:0]  rem_d;
    logic [RemW-1:0]  shifted;
    logic             bit_d;
    // Bits above the top quotient bit fold into the first partial remainder.
    if (s == 0) begin : g_first
      always_comb begin
        vld_in = valid_i;
        num_in = {num_i, 16'd0};
        den_in = den_i;
        quo_in = '0;
        tag_in = tag_i;
        shifted = RemW'(num_in[ExtW-1:QuotW-1]);
      end
    end else begin : g_rest
      always_comb begin
        vld_in = vld_q[s-1];
        num_in = num_q[s-1];
        den_in = den_q[s-1];
        quo_in = quo_q[s-1];
        tag_in = tag_q[s-1];
        shifted = {rem_q[s-1][RemW-2:0], num_q[s-1][QuotW-1-s]};
      end
    end
    always_comb begin
      trial = {1'b0, shifted} - {2'b0, den_in};
      bit_d = !trial[RemW];
      rem_d = bit_d ? trial[RemW-1:0] : shifted;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= num_in;
        rem_q[s] <= rem_d;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | ({{(QuotW-1){1'b0}}, bit_d} << (QuotW-1-s));
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = quo_q[QuotW-1];
  assign tag_o   = tag_q[QuotW-1];

endmodule

// ----- sv/plane_query_unit.sv -----
// Top level of the plane query unit: configuration registers, dot-product
// pipeline, divider and result stage. Depends on pqu_pkg and pqu_divider.
//
// Usage: write the normal, offset and threshold through cfg_we_i, cfg_idx_i
// and cfg_data_i while no request is in flight. Requests enter on req_valid_i
// / req_stall_o as a req_t; results leave on res_valid_o / res_stall_i as a
// res_t, one result per request, in order.
// Throughput: one request per cycle while the receiver does not stall. Every
// command takes the same path: three stages of products, sums and decisions,
// 33 divider stages (one quotient bit per stage) and the output register.
// The whole pipeline advances as one; when the receiver stalls with the
// output register full, every stage holds and req_stall_o rises, so nothing
// is lost or repeated. Reset clears all valid bits and loads the default
// configuration (normal zero, offset zero, threshold one).
module plane_query_unit import pqu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  req_t                req_i,
  output logic                res_valid_o,
  input  logic                res_stall_i,
  output res_t                res_o
);

  logic signed [15:0] nx_q, ny_q, nz_q;
  logic signed [31:0] off_q;
  logic [15:0]        thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= '0; ny_q <= '0; nz_q <= '0; off_q <= '0; thr_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNormalX:   nx_q <= cfg_data_i[15:0];
        RegNormalY:   ny_q <= cfg_data_i[15:0];
        RegNormalZ:   nz_q <= cfg_data_i[15:0];
        RegOffset:    off_q <= cfg_data_i;
        RegThreshold: thr_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic en;
  assign en = !(out_vld_q && res_stall_i);
  assign req_stall_o = !en;

  // Stage 1: products.
  logic               v1_q;
  req_t               r1_q;
  logic signed [47:0] pp1_q [3];
  logic signed [47:0] pe1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= req_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q <= req_i;
      pp1_q[0] <= nx_q * req_i.point_x;
      pp1_q[1] <= ny_q * req_i.point_y;
      pp1_q[2] <= nz_q * req_i.point_z;
      pe1_q[0] <= nx_q * req_i.extent_x;
      pe1_q[1] <= ny_q * req_i.extent_y;
      pe1_q[2] <= nz_q * req_i.extent_z;
    end
  end

  // Stage 2: sums.
  logic               v2_q;
  req_t               r2_q;
  logic signed [49:0] dot2_q, dist2_q, den2_q, reach2_q;
  logic signed [49:0] abs_e [3];
  logic signed [49:0] dot_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_e[i] = pe1_q[i][47] ? -50'(pe1_q[i]) : 50'(pe1_q[i]);
    end
    dot_d = 50'(pp1_q[0]) + 50'(pp1_q[1]) + 50'(pp1_q[2]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= r1_q;
      dot2_q <= dot_d;
      dist2_q <= dot_d - (50'(off_q) <<< 14);
      den2_q <= 50'(pe1_q[0]) + 50'(pe1_q[1]) + 50'(pe1_q[2]);
      reach2_q <= (r1_q.cmd == CmdBox) ? abs_e[0] + abs_e[1] + abs_e[2]
                                       : 50'({r1_q.radius, 14'd0});
    end
  end

  // Stage 3: decisions, projection products, divider operands.
  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         side;
    logic signed [31:0] distance;
    logic               ray_ok;
    logic               neg;
    logic signed [79:0] prx;
    logic signed [79:0] pry;
    logic signed [79:0] prz;
  } tag_t;

  logic               v3_q;
  tag_t               tag_d, tag3_q;
  logic [NumW-1:0]    num_d, num3_q;
  logic [DenW-1:0]    dd_d, den3_q;
  logic [49:0]        aden, anom;
  always_comb begin
    aden = den2_q[49] ? 50'(-den2_q) : 50'(den2_q);
    anom = dist2_q[49] ? 50'(-dist2_q) : 50'(dist2_q);
    tag_d = '0;
    tag_d.cmd = r2_q.cmd;
    tag_d.distance = sat_shift(80'(dist2_q), 14);
    if (r2_q.cmd == CmdPoint) begin
      tag_d.side = dist2_q < 0 ? SideNeg : (dist2_q > 0 ? SidePos : SideOn);
    end else begin
      tag_d.side = dist2_q < -reach2_q ? SideNeg
                 : (dist2_q > reach2_q ? SidePos : SideBoth);
    end
    tag_d.ray_ok = (aden >= 50'({thr_q, 14'd0})) && (aden != '0);
    tag_d.neg = (dist2_q != 0) && (dist2_q[49] == den2_q[49]);
    tag_d.prx = (80'(r2_q.point_x) <<< 28) - 80'(nx_q) * 80'(dot2_q);
    tag_d.pry = (80'(r2_q.point_y) <<< 28) - 80'(ny_q) * 80'(dot2_q);
    tag_d.prz = (80'(r2_q.point_z) <<< 28) - 80'(nz_q) * 80'(dot2_q);
    num_d = NumW'(anom);
    dd_d = tag_d.ray_ok ? aden[DenW-1:0] : {{(DenW-1){1'b0}}, 1'b1};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      tag3_q <= tag_d; num3_q <= num_d; den3_q <= dd_d;
    end
  end

  logic             v4;
  logic [QuotW-1:0] quot;
  tag_t             tag4;
  pqu_divider #(.TagW($bits(tag_t))) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .num_i(num3_q), .den_i(den3_q),
    .tag_i(tag3_q), .valid_o(v4), .quot_o(quot),
    .tag_o(tag4)
  );

  // Output stage.
  res_t               res_d;
  logic signed [31:0] t_d;
  always_comb begin
    if (quot[QuotW-1]) t_d = tag4.neg ? 32'sh80000000 : 32'sh7fffffff;
    else if (tag4.neg) t_d = (quot > 33'd2147483648) ? 32'sh80000000 : -quot[31:0];
    else t_d = (quot > 33'd2147483647) ? 32'sh7fffffff : quot[31:0];
    res_d = '0;
    unique case (tag4.cmd)
      CmdPoint, CmdBox, CmdSphere: begin
        res_d.side = tag4.side; res_d.distance = tag4.distance;
      end
      CmdRay: begin
        if (tag4.ray_ok) begin
          res_d.ray_t = t_d; res_d.hit = !t_d[31];
        end
      end
      CmdProject: begin
        res_d.proj_x = sat_shift(tag4.prx, 28);
        res_d.proj_y = sat_shift(tag4.pry, 28);
        res_d.proj_z = sat_shift(tag4.prz, 28);
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v4;
  end
  always_ff @(posedge clk_i) begin
    if (en) res_o <= res_d;
  end
  assign res_valid_o = out_vld_q;

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o))
    else $error("result changed under stall");
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_stall_o |-> res_valid_o && res_stall_i)
    else $error("request stalled without a stalled result");
  a_ray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.hit |-> !res_o.ray_t[31])
    else $error("hit with negative t");
`endif

endmodule

// ----- tb/pqu_checker.sv -----
`timescale 1ns / 100ps
// Checker for the plane query unit: mirrors the plane registers, predicts each
// query result and compares it with the block's output. Depends on pqu_pkg.
module pqu_checker import pqu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                req_valid_i,
  input  logic                req_stall_i,
  input  req_t                req_i,
  input  logic                res_valid_i,
  input  logic                res_stall_i,
  input  res_t                res_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic signed [15:0] nrm_x, nrm_y, nrm_z;
  logic signed [31:0] offset_q;
  logic [15:0]        par_thr;
  res_t               answers_q[$];

  function automatic logic signed [31:0] round_sat(input logic signed [127:0] v,
                                                   input int k);
    logic signed [127:0] r;
    r = (v + (128'sd1 <<< (k - 1))) >>> k;
    if (r > 128'sd2147483647) return 32'sh7fffffff;
    if (r < -128'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic logic signed [127:0] mag(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic res_t answer_query(input req_t rq);
    res_t r;
    logic signed [127:0] nx, ny, nz, dot, sdist, reach, den, aden, anom, ip, rem, q, t;
    logic neg;
    r = '0;
    nx = nrm_x; ny = nrm_y; nz = nrm_z;
    dot = nx * rq.point_x + ny * rq.point_y + nz * rq.point_z;
    sdist = dot - 128'(offset_q) * 16384;
    case (rq.cmd)
      CmdPoint: begin
        r.side = sdist < 0 ? SideNeg : (sdist > 0 ? SidePos : SideOn);
        r.distance = round_sat(sdist, 14);
      end
      CmdBox, CmdSphere: begin
        if (rq.cmd == CmdBox)
          reach = mag(nx * rq.extent_x) + mag(ny * rq.extent_y) + mag(nz * rq.extent_z);
        else
          reach = $signed({97'd0, rq.radius}) * 16384;
        r.side = sdist < -reach ? SideNeg : (sdist > reach ? SidePos : SideBoth);
        r.distance = round_sat(sdist, 14);
      end
      CmdRay: begin
        den = nx * rq.extent_x + ny * rq.extent_y + nz * rq.extent_z;
        aden = mag(den);
        if (aden >= $signed({112'd0, par_thr}) * 16384 && aden != 0) begin
          anom = mag(sdist);
          neg = (sdist != 0) && ((sdist < 0) == (den < 0));
          ip = anom / aden;
          rem = anom % aden;
          if (ip >= 65536) begin
            t = neg ? -128'sd2147483648 : 128'sd2147483647;
          end else begin
            q = (ip <<< 16) + ((rem <<< 16) / aden);
            if (neg) t = q > 128'sd2147483648 ? -128'sd2147483648 : -q;
            else t = q > 128'sd2147483647 ? 128'sd2147483647 : q;
          end
          r.hit = t >= 0;
          r.ray_t = t[31:0];
        end
      end
      CmdProject: begin
        r.proj_x = round_sat(128'(rq.point_x) * 268435456 - nx * dot, 28);
        r.proj_y = round_sat(128'(rq.point_y) * 268435456 - ny * dot, 28);
        r.proj_z = round_sat(128'(rq.point_z) * 268435456 - nz * dot, 28);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t w;
    if (!rst_ni) begin
      nrm_x <= '0; nrm_y <= '0; nrm_z <= '0; offset_q <= '0; par_thr <= 16'd1;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegNormalX: nrm_x <= cfg_data_i[15:0];
          RegNormalY: nrm_y <= cfg_data_i[15:0];
          RegNormalZ: nrm_z <= cfg_data_i[15:0];
          RegOffset: offset_q <= cfg_data_i;
          RegThreshold: par_thr <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (req_valid_i && !req_stall_i) answers_q.push_back(answer_query(req_i));
      if (res_valid_i && !res_stall_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected result", '0, '0);
        end else begin
          w = answers_q.pop_front();
          if (res_i.side != w.side) report_mismatch("side", res_i.side, w.side);
          if (res_i.distance != w.distance)
            report_mismatch("distance", res_i.distance, w.distance);
          if (res_i.hit != w.hit) report_mismatch("hit", res_i.hit, w.hit);
          if (res_i.ray_t != w.ray_t) report_mismatch("ray_t", res_i.ray_t, w.ray_t);
          if (res_i.proj_x != w.proj_x) report_mismatch("proj_x", res_i.proj_x, w.proj_x);
          if (res_i.proj_y != w.proj_y) report_mismatch("proj_y", res_i.proj_y, w.proj_y);
          if (res_i.proj_z != w.proj_z) report_mismatch("proj_z", res_i.proj_z, w.proj_z);
        end
      end
      pending_o = answers_q.size();
    end
  end

endmodule

// ----- tb/tb_plane_query_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for the plane query unit: clock, reset, plane settings and
// query stimulus, verdict. Depends on pqu_pkg, plane_query_unit, pqu_checker.
module tb_plane_query_unit;
  import pqu_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                req_valid_i = 1'b0;
  logic                req_stall_o;
  req_t                req_i = '0;
  logic                res_valid_o;
  logic                res_stall_i = 1'b0;
  res_t                res_o;
  int                  fail_count, pending;
  logic                long_req = 1'b0;
  logic                long_done = 1'b0;
  int                  stall_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  plane_query_unit u_top (.*);

  pqu_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_valid_i, .req_stall_i(req_stall_o), .req_i,
    .res_valid_i(res_valid_o), .res_stall_i, .res_i(res_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 20)) <<< 16)
                                     : -32'(int'($urandom_range(0, 20)) <<< 16);
      3: return 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
  endtask

  task automatic set_plane(input int nx, input int ny, input int nz, input logic [31:0] off,
                           input logic [15:0] thr);
    write_reg(RegNormalX, 32'(nx));
    write_reg(RegNormalY, 32'(ny));
    write_reg(RegNormalZ, 32'(nz));
    write_reg(RegOffset, off);
    write_reg(RegThreshold, {16'd0, thr});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(input req_t rq);
    req_valid_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int n);
    req_t rq;
    int g;
    repeat (n) begin
      g = gap_len();
      if (g > 0) begin
        req_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      rq.cmd = $urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      rq.point_x = rand_q(); rq.point_y = rand_q(); rq.point_z = rand_q();
      rq.extent_x = rand_q(); rq.extent_y = rand_q(); rq.extent_z = rand_q();
      rq.radius = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20));
      send(rq);
    end
    req_valid_i <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (45) @(negedge clk_i);
  endtask

  task automatic send_directed();
    req_t rq;
    for (int c = 0; c < 8; c++) begin
      rq = '0;
      rq.cmd = 3'(c);
      rq.point_x = 32'sh00010000; rq.point_y = 32'sh7fffffff; rq.point_z = 32'sh80000000;
      rq.extent_x = 32'sh00020000; rq.extent_y = -32'sh00010000; rq.extent_z = 32'sh80000000;
      rq.radius = 31'h7fffffff;
      send(rq);
      rq.point_x = 32'sh00030000; rq.point_y = '0; rq.point_z = '0;
      rq.extent_x = '0; rq.extent_y = '0; rq.extent_z = '0; rq.radius = '0;
      send(rq);
    end
    req_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) res_stall_i <= 1'b0;
      end else if (long_req && !long_done) begin
        res_stall_i <= 1'b1;
        stall_left = 120;
        long_done = 1'b1;
      end else if ($urandom_range(0, 9) < 2) begin
        res_stall_i <= 1'b1;
        stall_left = gap_len() + 1;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_directed();
    drain();
    set_plane(16384, 0, 0, 32'h00030000, 16'd1);
    send_directed();
    drain();
    set_plane(-16384, 0, 0, 32'h80000000, 16'hffff);
    send_directed();
    drain();
    set_plane(9459, -9459, 9459, 32'h7fffffff, 16'd0);
    send_random(100);
    drain();
    long_req = 1'b1;
    send_random(60);
    wait (long_done && stall_left == 0);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      set_plane($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                $urandom_range(0, 32768) - 16384, rand_q(), 16'($urandom_range(0, 300)));
      send_random(50);
      drain();
    end
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
